// ===== design/ffha_pkg.sv =====
package ffha_pkg;

    localparam int ARENA_BYTES  = 65536;
    localparam int HEADER_BYTES = 16;
    localparam int MAX_CHUNKS   = 64;
    localparam int MIN_ALLOC    = 4;
    localparam int SPLIT_SLACK  = 4;

    localparam int IDX_W = $clog2(MAX_CHUNKS);
    localparam int CNT_W = $clog2(MAX_CHUNKS + 1);
    localparam int SZ_W  = 17;
    localparam int OFS_W = 16;

    localparam logic [SZ_W-1:0] FULL_FREE = SZ_W'(ARENA_BYTES - HEADER_BYTES);
    localparam logic [SZ_W-1:0] HDR       = SZ_W'(HEADER_BYTES);

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_ZERO   = 3'd1;
    localparam logic [2:0] ST_NOFIT  = 3'd2;
    localparam logic [2:0] ST_FULL   = 3'd3;
    localparam logic [2:0] ST_INVAL  = 3'd4;
    localparam logic [2:0] ST_DOUBLE = 3'd5;

    typedef struct packed {
        logic [OFS_W-1:0] start;
        logic [SZ_W-1:0]  bytes;
        logic             free;
    } t_entry;

endpackage

// ===== design/first_fit_heap_allocator_top.sv =====
// First-fit allocator over one arena, kept as an address-ordered chunk table in a
// single-port-write, one-read RAM. One request is handled at a time: the table is
// scanned at one entry per cycle, a split or merge moves the entries above the
// chunk by one entry per cycle, and a successful allocate then rescans the table to
// recount the largest free chunk. The table holds at most 64 chunks. A zero-size
// allocate goes straight to the result without a scan. After reset the initial
// chunk is written in the init state before requests are taken. The next request
// is accepted while the previous result still waits at the output.
module first_fit_heap_allocator_top
    import ffha_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // req_size[15:0], free_offset[31:16]
    input  logic        i_s_tuser,   // cmd
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [55:0] o_m_tdata,   // payload_offset[15:0], bytes_allocated[32:16],
                                     // largest_free[49:33], zero fill above
    output logic [2:0]  o_m_tuser    // status
);

    localparam logic [3:0] S_INIT  = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_ASCAN = 4'd2;
    localparam logic [3:0] S_AHIT  = 4'd3;
    localparam logic [3:0] S_AWR1  = 4'd4;
    localparam logic [3:0] S_AWR2  = 4'd5;
    localparam logic [3:0] S_RSCAN = 4'd6;
    localparam logic [3:0] S_FSCAN = 4'd7;
    localparam logic [3:0] S_FNXT  = 4'd8;
    localparam logic [3:0] S_FWR   = 4'd9;
    localparam logic [3:0] S_COPY  = 4'd10;
    localparam logic [3:0] S_DONE  = 4'd11;

    t_entry mem [MAX_CHUNKS];
    t_entry rdata, wd;
    logic [IDX_W-1:0] ra, wa;
    logic we;

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        rdata <= mem[ra];
    end

    logic [3:0] r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [SZ_W-1:0] r_total, n_total, r_largest, n_largest;
    logic r_cmd, n_cmd;
    logic [SZ_W-1:0] r_want, n_want;
    logic [OFS_W-1:0] r_where, n_where;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic r_pend, n_pend;
    logic [IDX_W-1:0] r_pidx, n_pidx;
    logic [IDX_W-1:0] r_i, n_i;
    t_entry r_ent, n_ent, r_prev, n_prev;
    logic [SZ_W-1:0] r_gbytes, n_gbytes;
    logic [OFS_W-1:0] r_grant, n_grant;
    logic [2:0] r_status, n_status;
    logic [IDX_W-1:0] r_src, n_src, r_dst, n_dst, r_wdst, n_wdst;
    logic [CNT_W-1:0] r_ccnt, n_ccnt;
    logic r_cpend, n_cpend, r_cup, n_cup;
    logic [3:0] r_cret, n_cret;
    logic [IDX_W-1:0] r_m, n_m;
    logic [OFS_W-1:0] r_mstart, n_mstart;
    logic [SZ_W-1:0] r_mbytes, n_mbytes;
    logic r_ovalid, n_ovalid;
    logic [2:0] r_ostatus, n_ostatus;
    logic [49:0] r_odata, n_odata;

    logic in_acc, issue, drained, split, has_next, pm, nm;
    logic [SZ_W-1:0] req_ext, mb;
    logic [OFS_W:0] new_start;

    assign in_acc = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tuser = r_ostatus;
    assign o_m_tdata = {6'd0, r_odata};

    assign issue = (r_idx < r_count);
    assign drained = !r_pend && !issue;
    assign req_ext = {1'b0, i_s_tdata[15:0]};
    assign split = {1'b0, r_ent.bytes} > ({1'b0, r_want} + 18'(HEADER_BYTES + SPLIT_SLACK));
    assign has_next = ({1'b0, r_i} + 1'b1) < r_count;
    assign pm = (r_i != '0) && r_prev.free;
    assign nm = has_next && rdata.free;
    assign mb = r_ent.bytes + (pm ? r_prev.bytes + HDR : '0) + (nm ? rdata.bytes + HDR : '0);
    assign new_start = {1'b0, r_ent.start} + HDR + r_want;

    always_comb begin
        n_state = r_state;   n_count = r_count;   n_total = r_total;
        n_largest = r_largest; n_cmd = r_cmd;     n_want = r_want;
        n_where = r_where;   n_idx = r_idx;       n_pend = r_pend;
        n_pidx = r_pidx;     n_i = r_i;           n_ent = r_ent;
        n_prev = r_prev;     n_gbytes = r_gbytes; n_grant = r_grant;
        n_status = r_status; n_src = r_src;       n_dst = r_dst;
        n_wdst = r_wdst;     n_ccnt = r_ccnt;     n_cpend = r_cpend;
        n_cup = r_cup;       n_cret = r_cret;     n_m = r_m;
        n_mstart = r_mstart; n_mbytes = r_mbytes;
        n_ovalid = r_ovalid && !i_m_tready;
        n_ostatus = r_ostatus; n_odata = r_odata;
        we = 1'b0;
        wa = r_wdst;
        wd = rdata;
        ra = r_idx[IDX_W-1:0];

        // The table scans share one read pipeline: address now, data next cycle.
        if (r_state == S_ASCAN || r_state == S_FSCAN || r_state == S_RSCAN) begin
            n_idx = issue ? r_idx + 1'b1 : r_idx;
            n_pend = issue;
            n_pidx = r_idx[IDX_W-1:0];
        end

        case (r_state)
            S_INIT: begin
                we = 1'b1;
                wa = '0;
                wd = '{start: '0, bytes: FULL_FREE, free: 1'b1};
                n_state = S_IDLE;
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_cmd = i_s_tuser;
                    n_where = i_s_tdata[31:16];
                    n_want = (req_ext < SZ_W'(MIN_ALLOC)) ? SZ_W'(MIN_ALLOC) : req_ext;
                    n_grant = '0;
                    n_idx = '0;
                    n_pend = 1'b0;
                    if (i_s_tuser == CMD_FREE) begin
                        n_state = S_FSCAN;
                    end else if (i_s_tdata[15:0] == '0) begin
                        n_status = ST_ZERO;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_ASCAN;
                    end
                end
            end
            S_ASCAN: begin
                if (r_pend && rdata.free && rdata.bytes >= r_want) begin
                    n_i = r_pidx;
                    n_ent = rdata;
                    n_state = S_AHIT;
                end else if (drained) begin
                    n_status = ST_NOFIT;
                    n_state = S_DONE;
                end
            end
            S_AHIT: begin
                if (split && r_count >= CNT_W'(MAX_CHUNKS)) begin
                    n_status = ST_FULL;
                    n_state = S_DONE;
                end else if (split) begin
                    n_gbytes = r_want;
                    n_ccnt = r_count - CNT_W'(r_i) - 1'b1;
                    n_src = IDX_W'(r_count - 1'b1);
                    n_dst = IDX_W'(r_count);
                    n_cup = 1'b0;
                    n_cpend = 1'b0;
                    n_cret = S_AWR1;
                    n_state = S_COPY;
                end else begin
                    n_gbytes = r_ent.bytes;
                    n_state = S_AWR2;
                end
            end
            S_AWR1: begin
                we = 1'b1;
                wa = r_i + 1'b1;
                wd = '{start: new_start[OFS_W-1:0],
                       bytes: r_ent.bytes - r_want - HDR, free: 1'b1};
                n_count = r_count + 1'b1;
                n_state = S_AWR2;
            end
            S_AWR2: begin
                we = 1'b1;
                wa = r_i;
                wd = '{start: r_ent.start, bytes: r_gbytes, free: 1'b0};
                n_total = r_total + r_gbytes;
                n_grant = r_ent.start + OFS_W'(HEADER_BYTES);
                n_largest = '0;
                n_idx = '0;
                n_pend = 1'b0;
                n_state = S_RSCAN;
            end
            S_RSCAN: begin
                if (r_pend && rdata.free && rdata.bytes > r_largest) begin
                    n_largest = rdata.bytes;
                end
                if (drained) begin
                    n_status = ST_OK;
                    n_state = S_DONE;
                end
            end
            S_FSCAN: begin
                if (r_pend) begin
                    if (r_where == rdata.start + OFS_W'(HEADER_BYTES)) begin
                        n_i = r_pidx;
                        n_ent = rdata;
                        n_state = S_FNXT;
                    end else begin
                        n_prev = rdata;
                    end
                end else if (drained) begin
                    n_status = ST_INVAL;
                    n_state = S_DONE;
                end
            end
            S_FNXT: begin
                // rdata holds the next entry, read on the cycle the match was found.
                if (r_ent.free) begin
                    n_status = ST_DOUBLE;
                    n_state = S_DONE;
                end else begin
                    n_total = r_total - r_ent.bytes;
                    n_m = pm ? r_i - 1'b1 : r_i;
                    n_mstart = pm ? r_prev.start : r_ent.start;
                    n_mbytes = mb;
                    n_ccnt = r_count - CNT_W'(r_i) - 1'b1 - CNT_W'(nm);
                    n_src = r_i + 1'b1 + IDX_W'(nm);
                    n_dst = (pm ? r_i : r_i + 1'b1);
                    n_count = r_count - CNT_W'(pm) - CNT_W'(nm);
                    n_cup = 1'b1;
                    n_cpend = 1'b0;
                    n_cret = S_FWR;
                    n_state = S_COPY;
                end
            end
            S_FWR: begin
                we = 1'b1;
                wa = r_m;
                wd = '{start: r_mstart, bytes: r_mbytes, free: 1'b1};
                if (r_mbytes > r_largest) begin
                    n_largest = r_mbytes;
                end
                n_status = ST_OK;
                n_state = S_DONE;
            end
            S_COPY: begin
                // Move a run of entries: read one, write it back in the cycle after the read.
                ra = r_src;
                we = r_cpend;
                wa = r_wdst;
                wd = rdata;
                n_cpend = (r_ccnt != '0);
                if (r_ccnt != '0) begin
                    n_ccnt = r_ccnt - 1'b1;
                    n_wdst = r_dst;
                    n_src = r_cup ? r_src + 1'b1 : r_src - 1'b1;
                    n_dst = r_cup ? r_dst + 1'b1 : r_dst - 1'b1;
                end else if (!r_cpend) begin
                    n_state = r_cret;
                end
            end
            S_DONE: begin
                if (!r_ovalid || i_m_tready) begin
                    n_ovalid = 1'b1;
                    n_ostatus = r_status;
                    n_odata = {r_largest, r_total, r_grant};
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_count <= CNT_W'(1);
            r_total <= '0;
            r_largest <= FULL_FREE;
            r_pend <= 1'b0;
            r_cpend <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_total <= n_total;
            r_largest <= n_largest;
            r_pend <= n_pend;
            r_cpend <= n_cpend;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;       r_want <= n_want;     r_where <= n_where;
        r_idx <= n_idx;       r_pidx <= n_pidx;     r_i <= n_i;
        r_ent <= n_ent;       r_prev <= n_prev;     r_gbytes <= n_gbytes;
        r_grant <= n_grant;   r_status <= n_status; r_src <= n_src;
        r_dst <= n_dst;       r_wdst <= n_wdst;     r_ccnt <= n_ccnt;
        r_cup <= n_cup;       r_cret <= n_cret;     r_m <= n_m;
        r_mstart <= n_mstart; r_mbytes <= n_mbytes;
        r_ostatus <= n_ostatus; r_odata <= n_odata;
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != '0 && r_count <= CNT_W'(MAX_CHUNKS))
        else $error("chunk count out of range");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_state != S_IDLE)
        else $error("request accepted but block stayed idle");

    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= FULL_FREE)
        else $error("allocated total exceeds arena");

    a_cmd_free_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_cmd == CMD_FREE) |->
            (r_status == ST_OK || r_status == ST_INVAL || r_status == ST_DOUBLE))
        else $error("free request finished with an allocate status");

endmodule

// ===== verif/tb_first_fit_heap_allocator_top.sv =====
module tb_first_fit_heap_allocator_top;
    import ffha_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [31:0] i_s_tdata;   // req_size[15:0], free_offset[31:16]
    logic        i_s_tuser;   // cmd
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [55:0] o_m_tdata;   // payload_offset[15:0], bytes_allocated[32:16], largest_free[49:33]
    logic [2:0]  o_m_tuser;   // status

    first_fit_heap_allocator_top dut (.*);

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] grant;
        logic [16:0] in_use;
        logic [16:0] biggest;
    } t_outcome;

    typedef struct {
        logic        cmd;
        logic [15:0] size;
        logic [15:0] where;
        logic        typed;
        t_outcome    outcome;
    } t_row;

    // Predictor copy of the chunk table.
    logic [15:0] hp_start [MAX_CHUNKS];
    logic [16:0] hp_bytes [MAX_CHUNKS];
    logic        hp_free  [MAX_CHUNKS];
    int          hp_count;
    logic [16:0] hp_in_use;
    logic [16:0] hp_biggest;

    t_outcome outcome_q[$];
    t_row     rows[$];
    int       errors;
    bit       sending_done;
    logic [15:0] live_q[$];

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %0h want %0h", what, got, want);
        errors++;
    endtask

    function automatic void heap_reset();
        hp_start[0] = '0;
        hp_bytes[0] = FULL_FREE;
        hp_free[0]  = 1'b1;
        hp_count    = 1;
        hp_in_use   = '0;
        hp_biggest  = FULL_FREE;
    endfunction

    function automatic t_outcome heap_step(input logic cmd, input logic [15:0] size,
                                           input logic [15:0] where);
        t_outcome o;
        int i, k;
        logic [16:0] want;
        o = '0;
        if (cmd == CMD_ALLOC) begin
            want = {1'b0, size};
            if (size == 0) o.status = ST_ZERO;
            else begin
                if (want < MIN_ALLOC) want = 17'(MIN_ALLOC);
                for (i = 0; i < hp_count; i++)
                    if (hp_free[i] && hp_bytes[i] >= want) break;
                if (i >= hp_count) o.status = ST_NOFIT;
                else if (hp_bytes[i] > want + HEADER_BYTES + SPLIT_SLACK
                         && hp_count >= MAX_CHUNKS) o.status = ST_FULL;
                else begin
                    if (hp_bytes[i] > want + HEADER_BYTES + SPLIT_SLACK) begin
                        for (k = hp_count; k > i + 1; k--) begin
                            hp_start[k] = hp_start[k-1];
                            hp_bytes[k] = hp_bytes[k-1];
                            hp_free[k]  = hp_free[k-1];
                        end
                        hp_start[i+1] = 16'(hp_start[i] + HEADER_BYTES + want[15:0]);
                        hp_bytes[i+1] = hp_bytes[i] - want - HDR;
                        hp_free[i+1]  = 1'b1;
                        hp_bytes[i]   = want;
                        hp_count++;
                    end
                    hp_free[i] = 1'b0;
                    hp_in_use  = hp_in_use + hp_bytes[i];
                    hp_biggest = '0;
                    for (k = 0; k < hp_count; k++)
                        if (hp_free[k] && hp_bytes[k] > hp_biggest) hp_biggest = hp_bytes[k];
                    o.status = ST_OK;
                    o.grant  = 16'(hp_start[i] + HEADER_BYTES);
                end
            end
        end else begin
            for (i = 0; i < hp_count; i++)
                if (16'(hp_start[i] + HEADER_BYTES) == where) break;
            if (i >= hp_count) o.status = ST_INVAL;
            else if (hp_free[i]) o.status = ST_DOUBLE;
            else begin
                hp_in_use  = hp_in_use - hp_bytes[i];
                hp_free[i] = 1'b1;
                if (i > 0 && hp_free[i-1]) begin
                    hp_bytes[i-1] += hp_bytes[i] + HDR;
                    for (k = i; k + 1 < hp_count; k++) begin
                        hp_start[k] = hp_start[k+1];
                        hp_bytes[k] = hp_bytes[k+1];
                        hp_free[k]  = hp_free[k+1];
                    end
                    hp_count--;
                    i--;
                end
                if (i + 1 < hp_count && hp_free[i+1]) begin
                    hp_bytes[i] += hp_bytes[i+1] + HDR;
                    for (k = i + 1; k + 1 < hp_count; k++) begin
                        hp_start[k] = hp_start[k+1];
                        hp_bytes[k] = hp_bytes[k+1];
                        hp_free[k]  = hp_free[k+1];
                    end
                    hp_count--;
                end
                if (hp_bytes[i] > hp_biggest) hp_biggest = hp_bytes[i];
                o.status = ST_OK;
            end
        end
        o.in_use  = hp_in_use;
        o.biggest = hp_biggest;
        return o;
    endfunction

    task automatic send_request(input t_row r);
        t_outcome o;
        int gap;
        gap = $urandom_range(0, 5);
        if ($urandom_range(0, 3) == 0) gap = 0;
        // Valid stays high across back-to-back requests and drops only for a pause.
        if (gap != 0) i_s_tvalid <= 1'b0;
        repeat (gap) @(posedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= r.cmd;
        i_s_tdata  <= {r.where, r.size};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        o = heap_step(r.cmd, r.size, r.where);
        if (r.typed && o != r.outcome) report("directed row", 64'(o), 64'(r.outcome));
        if (r.cmd == CMD_ALLOC && o.status == ST_OK) live_q.push_back(o.grant);
        outcome_q.push_back(o);
    endtask

    function automatic t_row mk(input logic cmd, input logic [15:0] size,
                                input logic [15:0] where, input logic typed,
                                input logic [2:0] st, input logic [15:0] g,
                                input logic [16:0] u, input logic [16:0] b);
        t_row r;
        r.cmd = cmd; r.size = size; r.where = where; r.typed = typed;
        r.outcome = '{st, g, u, b};
        return r;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver with random stalls.
    initial begin
        t_outcome got, want;
        int hold;
        hold = 0;
        i_m_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_m_tready && o_m_tvalid) begin
                got = '{o_m_tuser, o_m_tdata[15:0], o_m_tdata[32:16], o_m_tdata[49:33]};
                if (outcome_q.size() == 0) report("unexpected result", 64'(got), '0);
                else begin
                    want = outcome_q.pop_front();
                    if (got.status !== want.status)
                        report("status", 64'(got.status), 64'(want.status));
                    if (got.grant !== want.grant)
                        report("offset", 64'(got.grant), 64'(want.grant));
                    if (got.in_use !== want.in_use)
                        report("allocated", 64'(got.in_use), 64'(want.in_use));
                    if (got.biggest !== want.biggest)
                        report("largest", 64'(got.biggest), 64'(want.biggest));
                end
                // Each result draws how long the receiver waits before the next one.
                hold = $urandom_range(0, 5);
                if (hold != 0) i_m_tready <= 1'b0;
            end else if (!i_m_tready) begin
                if (hold <= 1) i_m_tready <= 1'b1;
                hold--;
            end
        end
    end

    initial begin
        #20000000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        t_row r;
        int n, j;
        logic [15:0] sz;
        errors = 0;
        i_rst_n = 1'b0; i_s_tvalid = 1'b0; i_s_tdata = '0; i_s_tuser = 1'b0;
        heap_reset();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        rows.push_back(mk(CMD_ALLOC, 16'd0, 16'd0, 1'b1, ST_ZERO, '0, '0, FULL_FREE));
        rows.push_back(mk(CMD_FREE, '0, 16'd16, 1'b1, ST_DOUBLE, '0, '0, FULL_FREE));
        rows.push_back(mk(CMD_FREE, '0, 16'd0, 1'b1, ST_INVAL, '0, '0, FULL_FREE));
        rows.push_back(mk(CMD_ALLOC, 16'hFFFF, '0, 1'b1, ST_NOFIT, '0, '0, FULL_FREE));
        rows.push_back(mk(CMD_ALLOC, 16'd1, '0, 1'b1, ST_OK, 16'd16, 17'd4, 17'd65500));
        rows.push_back(mk(CMD_ALLOC, 16'd24, '0, 1'b0, ST_OK, '0, '0, '0));
        rows.push_back(mk(CMD_FREE, '0, 16'd16, 1'b0, ST_OK, '0, '0, '0));
        rows.push_back(mk(CMD_FREE, '0, 16'd36, 1'b0, ST_OK, '0, '0, '0));
        rows.push_back(mk(CMD_ALLOC, 16'd65520, '0, 1'b1, ST_OK, 16'd16, 17'd65520, 17'd0));
        rows.push_back(mk(CMD_ALLOC, 16'd4, '0, 1'b1, ST_NOFIT, '0, 17'd65520, 17'd0));
        rows.push_back(mk(CMD_FREE, '0, 16'd16, 1'b1, ST_OK, '0, 17'd0, FULL_FREE));
        rows.push_back(mk(CMD_ALLOC, 16'd65500, '0, 1'b0, ST_OK, '0, '0, '0));  // no split, surplus small
        rows.push_back(mk(CMD_FREE, '0, 16'd16, 1'b0, ST_OK, '0, '0, '0));
        rows.push_back(mk(CMD_FREE, '0, 16'hFFFF, 1'b0, ST_OK, '0, '0, '0));
        foreach (rows[i]) send_request(rows[i]);
        live_q.delete();

        // Fill the table with small chunks to reach the table-full case.
        for (j = 0; j < 66; j++) send_request(mk(CMD_ALLOC, 16'd8, '0, 1'b0, ST_OK, '0, '0, '0));

        // Sender holds off until the block has drained.
        i_s_tvalid <= 1'b0;
        while (outcome_q.size() != 0) @(posedge i_clk);

        for (n = 0; n < 1150; n++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    sz = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 600));
                    r = mk(CMD_ALLOC, sz, 16'($urandom), 1'b0, ST_OK, '0, '0, '0);
                end
                4, 5, 6, 7: begin
                    if (live_q.size() != 0) begin
                        j = $urandom_range(0, live_q.size() - 1);
                        r = mk(CMD_FREE, 16'($urandom), live_q[j], 1'b0, ST_OK, '0, '0, '0);
                        if ($urandom_range(0, 4) != 0) live_q.delete(j);
                    end else begin
                        r = mk(CMD_FREE, 16'($urandom), 16'($urandom), 1'b0, ST_OK,
                               '0, '0, '0);
                    end
                end
                8: r = mk(CMD_FREE, 16'($urandom), 16'($urandom), 1'b0, ST_OK, '0, '0, '0);
                default: r = mk(CMD_ALLOC, 16'($urandom_range(0, 3)), 16'($urandom), 1'b0,
                                ST_OK, '0, '0, '0);
            endcase
            send_request(r);
        end
        send_request(mk(CMD_ALLOC, 16'hFFFF, 16'hFFFF, 1'b0, ST_OK, '0, '0, '0));
        send_request(mk(CMD_FREE, 16'hFFFF, 16'hFFFF, 1'b0, ST_OK, '0, '0, '0));
        i_s_tvalid <= 1'b0;

        while (outcome_q.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (errors == 0 && outcome_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

// ===== first_fit_heap_allocator_top.f =====
design/ffha_pkg.sv
design/first_fit_heap_allocator_top.sv
verif/tb_first_fit_heap_allocator_top.sv
